[rtl/ffn_pkg.sv]
package ffn_pkg;

  localparam int OPCODE_W = 3;
  localparam int ADDR_W = 14;
  localparam int DATA_W = 8;
  localparam int INDEX_W = 6;
  localparam int ACC_W = 26;
  localparam int SUM_W = ACC_W + 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [OPCODE_W-1:0] OP_W1 = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_B1 = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_W2 = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_B2 = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_TOKEN = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_TOKEN_DIM = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HIDDEN_DIM = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_QSHIFT = 2'd2;

  localparam logic [6:0] TOKEN_DIM_RST = 7'd32;
  localparam logic [8:0] HIDDEN_DIM_RST = 9'd64;
  localparam logic [3:0] QSHIFT_RST = 4'd7;

  localparam logic signed [SUM_W-1:0] SAT_MAX = 28'sd127;
  localparam logic signed [SUM_W-1:0] SAT_MIN = -28'sd128;

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic [ADDR_W-1:0]        address;
    logic signed [DATA_W-1:0] value;
    logic                     end_of_token;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [INDEX_W-1:0]       result_index;
    logic                     last_result;
  } out_beat_t;

  typedef struct packed {
    logic issue;
    logic first;
    logic last;
    logic layer2;
    logic row_last;
  } ffn_cmd_t;

  typedef struct packed {
    logic row_done;
    logic out_taken;
  } ffn_stat_t;

endpackage

[rtl/int8_relu_feed_forward_network_core.sv]
// Int8 two-layer feed-forward network with ReLU on the hidden layer.
// Input channel (in_valid/in_ready/in_data): each beat writes one int8 weight,
// bias or token element into its store when its address is in range. A token
// element beat with end_of_token set starts the computation after its write.
// Result channel (out_valid/out_ready/out_data): token_dim beats per token,
// in index order, the final one with last_result set.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; index 0 is token_dim, 1 hidden_dim, 2 the requantization shift.
// Load beats are taken back to back while idle. A token runs on a single
// multiply-accumulate unit, one product per cycle while a row is issued, with
// a four-stage read/multiply/accumulate/requantize pipeline that drains at the
// end of each row before the next row starts; the second layer also waits
// whenever the receiver holds out_ready low. No new input beat is
// taken until the last result has been delivered. A stalled receiver freezes
// the computation on the pending result. Reset returns the registers to
// 32, 64 and 7 and the control to idle; the stores keep no reset value.
module int8_relu_feed_forward_network_core #(
  parameter int MAX_TOKEN_DIM = 64,
  parameter int MAX_HIDDEN_DIM = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ffn_pkg::in_beat_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ffn_pkg::out_beat_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ffn_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ffn_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ffn_pkg::*;

  localparam int TAW = (MAX_TOKEN_DIM > 1) ? $clog2(MAX_TOKEN_DIM) : 1;
  localparam int HAW = (MAX_HIDDEN_DIM > 1) ? $clog2(MAX_HIDDEN_DIM) : 1;
  localparam int RW = (TAW > HAW) ? TAW : HAW;
  localparam int WAW = $clog2(MAX_TOKEN_DIM*MAX_HIDDEN_DIM);
  localparam int TDW = $clog2(MAX_TOKEN_DIM+1);
  localparam int HDW = $clog2(MAX_HIDDEN_DIM+1);

  logic [6:0]     token_dim_r;
  logic [8:0]     hidden_dim_r;
  logic [3:0]     qshift_r;
  logic [TDW-1:0] dt;
  logic [HDW-1:0] df;
  logic           idle;
  logic           in_wr;
  logic           start;
  ffn_cmd_t       cmd;
  ffn_stat_t      stat;
  logic [RW-1:0]  k_idx;
  logic [RW-1:0]  row;
  logic [WAW-1:0] waddr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_dim_r <= TOKEN_DIM_RST;
      hidden_dim_r <= HIDDEN_DIM_RST;
      qshift_r <= QSHIFT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TOKEN_DIM: token_dim_r <= cfg_data[6:0];
        CFG_HIDDEN_DIM: hidden_dim_r <= cfg_data[8:0];
        CFG_QSHIFT: qshift_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (token_dim_r == '0) begin
      dt = TDW'(1);
    end else if (32'(token_dim_r) > MAX_TOKEN_DIM) begin
      dt = TDW'(MAX_TOKEN_DIM);
    end else begin
      dt = TDW'(token_dim_r);
    end
    if (hidden_dim_r == '0) begin
      df = HDW'(1);
    end else if (32'(hidden_dim_r) > MAX_HIDDEN_DIM) begin
      df = HDW'(MAX_HIDDEN_DIM);
    end else begin
      df = HDW'(hidden_dim_r);
    end
  end

  assign in_ready = idle;
  assign in_wr = in_valid && in_ready;
  assign start = in_wr && in_data.opcode == OP_TOKEN && in_data.end_of_token;

  ffn_ctrl #(
    .MAX_TOKEN_DIM(MAX_TOKEN_DIM),
    .MAX_HIDDEN_DIM(MAX_HIDDEN_DIM)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .dt(dt),
    .df(df),
    .stat(stat),
    .cmd(cmd),
    .idle(idle),
    .k_idx(k_idx),
    .row(row),
    .waddr(waddr)
  );

  ffn_dp #(
    .MAX_TOKEN_DIM(MAX_TOKEN_DIM),
    .MAX_HIDDEN_DIM(MAX_HIDDEN_DIM)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .in_wr(in_wr),
    .in_data(in_data),
    .qshift(qshift_r),
    .cmd(cmd),
    .k_idx(k_idx),
    .row(row),
    .waddr(waddr),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data(out_data),
    .stat(stat)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ready)
    else $error("block still ready after end of token");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_result) |=> in_ready)
    else $error("block not idle after last result");

  a_row_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.row_done |-> !idle)
    else $error("row finished while idle");

endmodule

[rtl/ffn_ctrl.sv]
module ffn_ctrl #(
  parameter int MAX_TOKEN_DIM = 64,
  parameter int MAX_HIDDEN_DIM = 256
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic [$clog2(MAX_TOKEN_DIM+1)-1:0]       dt,
  input  logic [$clog2(MAX_HIDDEN_DIM+1)-1:0]      df,
  input  ffn_pkg::ffn_stat_t                       stat,
  output ffn_pkg::ffn_cmd_t                        cmd,
  output logic                                     idle,
  output logic [((MAX_TOKEN_DIM > 1) ? $clog2(MAX_TOKEN_DIM) : 1) >
                ((MAX_HIDDEN_DIM > 1) ? $clog2(MAX_HIDDEN_DIM) : 1) ?
                ((MAX_TOKEN_DIM > 1) ? $clog2(MAX_TOKEN_DIM) : 1) - 1 :
                ((MAX_HIDDEN_DIM > 1) ? $clog2(MAX_HIDDEN_DIM) : 1) - 1:0] k_idx,
  output logic [((MAX_TOKEN_DIM > 1) ? $clog2(MAX_TOKEN_DIM) : 1) >
                ((MAX_HIDDEN_DIM > 1) ? $clog2(MAX_HIDDEN_DIM) : 1) ?
                ((MAX_TOKEN_DIM > 1) ? $clog2(MAX_TOKEN_DIM) : 1) - 1 :
                ((MAX_HIDDEN_DIM > 1) ? $clog2(MAX_HIDDEN_DIM) : 1) - 1:0] row,
  output logic [$clog2(MAX_TOKEN_DIM*MAX_HIDDEN_DIM)-1:0] waddr
);
  import ffn_pkg::*;

  localparam int TAW = (MAX_TOKEN_DIM > 1) ? $clog2(MAX_TOKEN_DIM) : 1;
  localparam int HAW = (MAX_HIDDEN_DIM > 1) ? $clog2(MAX_HIDDEN_DIM) : 1;
  localparam int RW = (TAW > HAW) ? TAW : HAW;
  localparam int WAW = $clog2(MAX_TOKEN_DIM*MAX_HIDDEN_DIM);
  localparam int TDW = $clog2(MAX_TOKEN_DIM+1);
  localparam int HDW = $clog2(MAX_HIDDEN_DIM+1);
  localparam int DW = ((TDW > HDW) ? TDW : HDW) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_DRAIN, S_OUT
  } state_t;

  state_t        state_r;
  logic          layer2_r;
  logic [RW-1:0] k_r;
  logic [RW-1:0] o_r;
  logic [WAW-1:0] base_r;
  logic [DW-1:0] k_end;
  logic [DW-1:0] o_end;
  logic          k_at_end;
  logic          o_at_end;

  assign k_end = layer2_r ? DW'(df) - DW'(1) : DW'(dt) - DW'(1);
  assign o_end = layer2_r ? DW'(dt) - DW'(1) : DW'(df) - DW'(1);
  assign k_at_end = (DW'(k_r) == k_end);
  assign o_at_end = (DW'(o_r) == o_end);

  assign cmd.issue = (state_r == S_ISSUE);
  assign cmd.first = (k_r == '0);
  assign cmd.last = k_at_end;
  assign cmd.layer2 = layer2_r;
  assign cmd.row_last = o_at_end;
  assign idle = (state_r == S_IDLE);
  assign k_idx = k_r;
  assign row = o_r;
  assign waddr = base_r + WAW'(k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      layer2_r <= 1'b0;
      k_r <= '0;
      o_r <= '0;
      base_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_ISSUE;
            layer2_r <= 1'b0;
            k_r <= '0;
            o_r <= '0;
            base_r <= '0;
          end
        end
        S_ISSUE: begin
          if (k_at_end) begin
            state_r <= S_DRAIN;
          end else begin
            k_r <= k_r + RW'(1);
          end
        end
        S_DRAIN: begin
          if (stat.row_done) begin
            k_r <= '0;
            if (layer2_r) begin
              state_r <= S_OUT;
            end else if (o_at_end) begin
              state_r <= S_ISSUE;
              layer2_r <= 1'b1;
              o_r <= '0;
              base_r <= '0;
            end else begin
              state_r <= S_ISSUE;
              o_r <= o_r + RW'(1);
              base_r <= base_r + WAW'(dt);
            end
          end
        end
        S_OUT: begin
          if (stat.out_taken) begin
            if (o_at_end) begin
              state_r <= S_IDLE;
            end else begin
              state_r <= S_ISSUE;
              o_r <= o_r + RW'(1);
              base_r <= base_r + WAW'(df);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/ffn_dp.sv]
module ffn_dp #(
  parameter int MAX_TOKEN_DIM = 64,
  parameter int MAX_HIDDEN_DIM = 256
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_wr,
  input  ffn_pkg::in_beat_t                        in_data,
  input  logic [3:0]                               qshift,
  input  ffn_pkg::ffn_cmd_t                        cmd,
  input  logic [((MAX_TOKEN_DIM > 1) ? $clog2(MAX_TOKEN_DIM) : 1) >
                ((MAX_HIDDEN_DIM > 1) ? $clog2(MAX_HIDDEN_DIM) : 1) ?
                ((MAX_TOKEN_DIM > 1) ? $clog2(MAX_TOKEN_DIM) : 1) - 1 :
                ((MAX_HIDDEN_DIM > 1) ? $clog2(MAX_HIDDEN_DIM) : 1) - 1:0] k_idx,
  input  logic [((MAX_TOKEN_DIM > 1) ? $clog2(MAX_TOKEN_DIM) : 1) >
                ((MAX_HIDDEN_DIM > 1) ? $clog2(MAX_HIDDEN_DIM) : 1) ?
                ((MAX_TOKEN_DIM > 1) ? $clog2(MAX_TOKEN_DIM) : 1) - 1 :
                ((MAX_HIDDEN_DIM > 1) ? $clog2(MAX_HIDDEN_DIM) : 1) - 1:0] row,
  input  logic [$clog2(MAX_TOKEN_DIM*MAX_HIDDEN_DIM)-1:0] waddr,
  input  logic                                     out_ready,
  output logic                                     out_valid,
  output ffn_pkg::out_beat_t                       out_data,
  output ffn_pkg::ffn_stat_t                       stat
);
  import ffn_pkg::*;

  localparam int TAW = (MAX_TOKEN_DIM > 1) ? $clog2(MAX_TOKEN_DIM) : 1;
  localparam int HAW = (MAX_HIDDEN_DIM > 1) ? $clog2(MAX_HIDDEN_DIM) : 1;
  localparam int WDEPTH = MAX_TOKEN_DIM * MAX_HIDDEN_DIM;
  localparam int WAW = $clog2(WDEPTH);
  localparam int XW = ((WAW > ADDR_W) ? WAW : ADDR_W) + 1;

  logic signed [DATA_W-1:0] w1_mem [WDEPTH];
  logic signed [DATA_W-1:0] w2_mem [WDEPTH];
  logic signed [DATA_W-1:0] b1_mem [MAX_HIDDEN_DIM];
  logic signed [DATA_W-1:0] b2_mem [MAX_TOKEN_DIM];
  logic signed [DATA_W-1:0] tok_mem [MAX_TOKEN_DIM];
  logic signed [DATA_W-1:0] hid_mem [MAX_HIDDEN_DIM];

  logic [XW-1:0]            addr_x;
  logic                     a_vld_r, a_first_r, a_last_r;
  logic                     b_vld_r, b_first_r, b_last_r;
  logic signed [DATA_W-1:0] w1_q_r, w2_q_r, b1_q_r, b2_q_r, tok_q_r, hid_q_r;
  logic signed [15:0]       prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     rq_r;
  logic                     out_vld_r;
  out_beat_t                out_r;
  logic signed [DATA_W-1:0] x_sel, w_sel, b_sel;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shifted;
  logic signed [DATA_W-1:0] sat;
  logic signed [DATA_W-1:0] relu;

  assign addr_x = XW'(in_data.address);

  always_ff @(posedge clk) begin
    if (in_wr && in_data.opcode == OP_W1 && addr_x < XW'(WDEPTH)) begin
      w1_mem[addr_x[WAW-1:0]] <= in_data.value;
    end
    w1_q_r <= w1_mem[waddr];
  end

  always_ff @(posedge clk) begin
    if (in_wr && in_data.opcode == OP_W2 && addr_x < XW'(WDEPTH)) begin
      w2_mem[addr_x[WAW-1:0]] <= in_data.value;
    end
    w2_q_r <= w2_mem[waddr];
  end

  always_ff @(posedge clk) begin
    if (in_wr && in_data.opcode == OP_B1 && addr_x < XW'(MAX_HIDDEN_DIM)) begin
      b1_mem[addr_x[HAW-1:0]] <= in_data.value;
    end
    b1_q_r <= b1_mem[row[HAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_wr && in_data.opcode == OP_B2 && addr_x < XW'(MAX_TOKEN_DIM)) begin
      b2_mem[addr_x[TAW-1:0]] <= in_data.value;
    end
    b2_q_r <= b2_mem[row[TAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_wr && in_data.opcode == OP_TOKEN && addr_x < XW'(MAX_TOKEN_DIM)) begin
      tok_mem[addr_x[TAW-1:0]] <= in_data.value;
    end
    tok_q_r <= tok_mem[k_idx[TAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rq_r && !cmd.layer2) begin
      hid_mem[row[HAW-1:0]] <= relu;
    end
    hid_q_r <= hid_mem[k_idx[HAW-1:0]];
  end

  assign x_sel = cmd.layer2 ? hid_q_r : tok_q_r;
  assign w_sel = cmd.layer2 ? w2_q_r : w1_q_r;
  assign b_sel = cmd.layer2 ? b2_q_r : b1_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      rq_r <= 1'b0;
    end else begin
      a_vld_r <= cmd.issue;
      b_vld_r <= a_vld_r;
      rq_r <= b_vld_r && b_last_r;
    end
  end

  always_ff @(posedge clk) begin
    a_first_r <= cmd.first;
    a_last_r <= cmd.last;
    b_first_r <= a_first_r;
    b_last_r <= a_last_r;
    prod_r <= x_sel * w_sel;
    if (b_vld_r) begin
      acc_r <= b_first_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  always_comb begin
    sum = SUM_W'(acc_r) + (SUM_W'(b_sel) <<< qshift);
    if (qshift != 4'd0) begin
      sum = sum + (SUM_W'(1) << (qshift - 4'd1));
    end
    shifted = sum >>> qshift;
    if (shifted > SAT_MAX) begin
      sat = DATA_W'(SAT_MAX);
    end else if (shifted < SAT_MIN) begin
      sat = DATA_W'(SAT_MIN);
    end else begin
      sat = DATA_W'(shifted);
    end
    relu = sat[DATA_W-1] ? '0 : sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (rq_r && cmd.layer2) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rq_r && cmd.layer2) begin
      out_r.result_value <= sat;
      out_r.result_index <= INDEX_W'(row);
      out_r.last_result <= cmd.row_last;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data = out_r;
  assign stat.row_done = rq_r;
  assign stat.out_taken = out_vld_r && out_ready;

endmodule
